>>> sv/csrf_pkg.sv
// Shared types, constants and helpers for the control and status register file.
package csrf_pkg;

   localparam int PADDR_ENTRIES_DEF = 64;
   localparam int PCFG_WORDS_DEF    = 8;

   localparam int DIV_STAGES  = 4;
   localparam int DIV_CHUNK   = 16;
   localparam int DIV_REM_W   = 5;
   localparam int DIV_NUM_W   = DIV_REM_W + DIV_CHUNK;
   localparam int DIV_SHIFT   = 26;
   localparam int DIV_PROD_W  = 43;
   localparam logic [DIV_PROD_W-1:0] DIV25_RECIP = 43'd2684355;
   localparam logic [DIV_NUM_W-1:0]  DIV25       = 21'd25;

   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_STATUS_VIEW_MASK = 1'b0,
      CFG_ISA              = 1'b1
   } cfg_index_type;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [11:0] addr;
      logic [63:0] wdata;
      logic [1:0]  mode;
      logic [63:0] steps;
   } item_type;

   typedef struct packed {
      item_type               item;
      logic [63:0]            quot;
      logic [DIV_REM_W-1:0]   rem;
   } stage_type;

   typedef struct packed {
      logic [63:0] mstatus;
      logic [63:0] medeleg;
      logic [63:0] mideleg;
      logic [63:0] mie;
      logic [63:0] mip;
      logic [63:0] mtvec;
      logic [63:0] mscratch;
      logic [63:0] mepc;
      logic [63:0] mcause;
      logic [63:0] mtval;
      logic [63:0] mcounteren;
      logic [63:0] menvcfg;
      logic [63:0] senvcfg;
      logic [63:0] stvec;
      logic [63:0] sscratch;
      logic [63:0] sepc;
      logic [63:0] scause;
      logic [63:0] stval;
      logic [63:0] satp;
      logic [63:0] scounteren;
      logic [7:0]  fcsr;
   } csr_state_type;

   // Quotient of a value below 25 * 2**16 by 25, by reciprocal multiply.
   function automatic logic [DIV_CHUNK-1:0] div25(input logic [DIV_NUM_W-1:0] v);
      logic [DIV_PROD_W-1:0] p;
      p = DIV_PROD_W'(v) * DIV25_RECIP;
      return p[DIV_SHIFT +: DIV_CHUNK];
   endfunction

endpackage

>>> sv/csrf_div_stage.sv
// One pipeline stage of the time divider: one 16-bit digit of the step total / 100.
module csrf_div_stage #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  csrf_pkg::stage_type  in_stage,
   output logic                 out_valid,
   output csrf_pkg::stage_type  out_stage
);
   import csrf_pkg::*;

   localparam int TOP_BIT = 63 - DIV_CHUNK * STAGE;

   logic [63:0]           scaled;
   logic [DIV_NUM_W-1:0]  num;
   logic [DIV_CHUNK-1:0]  q;
   logic [DIV_NUM_W-1:0]  r;
   stage_type             stage_in;
   stage_type             stage_ff;
   logic                  valid_ff;

   // divide by 4 first, then long division by 25 one digit per stage
   always_comb begin
      scaled         = {2'b00, in_stage.item.steps[63:2]};
      num            = {in_stage.rem, scaled[TOP_BIT -: DIV_CHUNK]};
      q              = div25(num);
      r              = num - DIV_NUM_W'(q) * DIV25;
      stage_in       = in_stage;
      stage_in.quot  = {in_stage.quot[63-DIV_CHUNK:0], q};
      stage_in.rem   = r[DIV_REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

>>> sv/csrf_regs.sv
// Register state, address decode, masked views and the result register.
module csrf_regs #(
   parameter int PADDR_ENTRIES = csrf_pkg::PADDR_ENTRIES_DEF,
   parameter int PCFG_WORDS    = csrf_pkg::PCFG_WORDS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               csr_we,
   input  logic [csrf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_wdata,
   input  logic [11:0]                        pre_addr,
   input  logic                               in_valid,
   input  csrf_pkg::stage_type                in_stage,
   output logic                               rsp_valid,
   output logic [63:0]                        rsp_data,
   output logic                               rsp_illegal
);
   import csrf_pkg::*;

   localparam int PA_DEPTH = (PADDR_ENTRIES > 1) ? PADDR_ENTRIES : 1;
   localparam int PA_W     = (PA_DEPTH > 1) ? $clog2(PA_DEPTH) : 1;
   localparam int PC_DEPTH = (PCFG_WORDS > 1) ? PCFG_WORDS : 1;
   localparam int PC_W     = (PC_DEPTH > 1) ? $clog2(PC_DEPTH) : 1;

   localparam logic [11:0] A_FFLAGS = 12'h001, A_FRM = 12'h002, A_FCSR = 12'h003;
   localparam logic [11:0] A_SEED = 12'h015;
   localparam logic [11:0] A_SSTATUS = 12'h100, A_SSTATUS_ALT = 12'h120;
   localparam logic [11:0] A_SIE = 12'h104, A_STVEC = 12'h105, A_SCOUNTEREN = 12'h106;
   localparam logic [11:0] A_SENVCFG = 12'h10A, A_SSCRATCH = 12'h140, A_SEPC = 12'h141;
   localparam logic [11:0] A_SCAUSE = 12'h142, A_STVAL = 12'h143, A_SIP = 12'h144;
   localparam logic [11:0] A_SATP = 12'h180;
   localparam logic [11:0] A_MSTATUS = 12'h300, A_MISA = 12'h301, A_MEDELEG = 12'h302;
   localparam logic [11:0] A_MIDELEG = 12'h303, A_MIE = 12'h304, A_MTVEC = 12'h305;
   localparam logic [11:0] A_MCOUNTEREN = 12'h306, A_MENVCFG = 12'h30A;
   localparam logic [11:0] A_MSCRATCH = 12'h340, A_MEPC = 12'h341, A_MCAUSE = 12'h342;
   localparam logic [11:0] A_MTVAL = 12'h343, A_MIP = 12'h344;
   localparam logic [11:0] A_MCYCLE = 12'hB00, A_MINSTRET = 12'hB02;
   localparam logic [11:0] A_CYCLE = 12'hC00, A_TIME = 12'hC01, A_INSTRET = 12'hC02;
   localparam logic [11:0] A_MVENDOR = 12'hF11, A_MARCH = 12'hF12, A_MIMP = 12'hF13;
   localparam logic [11:0] A_MHART = 12'hF14;
   localparam logic [11:0] PCFG_LO = 12'h3A0, PCFG_HI = 12'h3AF;
   localparam logic [11:0] PADDR_LO = 12'h3B0, PADDR_HI = 12'h3EF;
   localparam logic [11:0] ZERO_A_LO = 12'hB03, ZERO_A_HI = 12'hB1F;
   localparam logic [11:0] ZERO_B_LO = 12'h320, ZERO_B_HI = 12'h33F;
   localparam logic [63:0] MARCH_VALUE = 64'h8000_0000;
   localparam logic [63:0] MIMP_VALUE  = 64'h2024_0501;
   localparam logic [7:0]  FFLAGS_MASK = 8'h1F;
   localparam logic [7:0]  FRM_MASK    = 8'hE0;
   localparam logic [63:0] STATUS_VIEW_MASK_RST = 64'h8000_0003_000D_E762;
   localparam logic [63:0] ISA_RST              = 64'h8000_0000_0000_0100;
   localparam logic [63:0] MEDELEG_WARL = ~(64'd1 << 11);
   localparam logic [63:0] MIDELEG_WARL = ~((64'd1 << 7) | (64'd1 << 3));

   csr_state_type state_ff, state_in, wr_next;
   logic [63:0]   status_view_mask_ff, isa_ff;
   logic [63:0]   pcfg_ff [PC_DEPTH];
   logic [63:0]   paddr_mem [PA_DEPTH];
   logic          paddr_vld_ff [PA_DEPTH];
   logic [63:0]   paddr_rd_ff;
   logic          rsp_valid_ff, rsp_illegal_ff;
   logic [63:0]   rsp_data_ff;

   item_type      it;
   logic [11:0]   a;
   logic          in_pcfg, in_paddr, in_zero;
   logic          pcfg_hit, paddr_hit;
   logic [PC_W-1:0] pcfg_idx;
   logic [6:0]    paddr_off, pre_off;
   logic [PA_W-1:0] paddr_idx, pre_idx;
   logic          rd_ok, wr_ok, bad;
   logic [63:0]   rd_val;
   logic          fire, wr_fire;
   logic          pcfg_we, paddr_we;

   always_comb begin
      it        = in_stage.item;
      a         = it.addr;
      in_pcfg   = (a >= PCFG_LO) && (a <= PCFG_HI);
      in_paddr  = (a >= PADDR_LO) && (a <= PADDR_HI);
      in_zero   = ((a >= ZERO_A_LO) && (a <= ZERO_A_HI)) ||
                  ((a >= ZERO_B_LO) && (a <= ZERO_B_HI));
      pcfg_hit  = !a[0] && ({29'd0, a[3:1]} < PCFG_WORDS);
      pcfg_idx  = PC_W'(a[3:1]);
      paddr_off = 7'(a - PADDR_LO);
      paddr_hit = ({25'd0, paddr_off} < PADDR_ENTRIES);
      paddr_idx = PA_W'(paddr_off);
      pre_off   = 7'(pre_addr - PADDR_LO);
      pre_idx   = PA_W'(pre_off);
   end

   // read decode
   always_comb begin
      rd_ok  = 1'b0;
      rd_val = '0;
      if (in_pcfg) begin
         rd_ok = 1'b1;
         if (pcfg_hit) rd_val = pcfg_ff[pcfg_idx];
      end else if (in_paddr) begin
         rd_ok = 1'b1;
         if (paddr_hit) rd_val = paddr_rd_ff;
      end else if (in_zero) begin
         rd_ok = 1'b1;
      end else begin
         rd_ok = 1'b1;
         unique case (a) inside
            A_SEED, A_MVENDOR, A_MHART: rd_val = '0;
            A_SSTATUS, A_SSTATUS_ALT: rd_val = state_ff.mstatus & status_view_mask_ff;
            A_MSTATUS:    rd_val = state_ff.mstatus;
            A_MISA:       rd_val = isa_ff;
            A_MEDELEG:    rd_val = state_ff.medeleg;
            A_MIDELEG:    rd_val = state_ff.mideleg;
            A_MIE:        rd_val = state_ff.mie;
            A_MTVEC:      rd_val = state_ff.mtvec;
            A_MCOUNTEREN: rd_val = state_ff.mcounteren;
            A_MENVCFG:    rd_val = state_ff.menvcfg;
            A_MSCRATCH:   rd_val = state_ff.mscratch;
            A_MEPC:       rd_val = state_ff.mepc;
            A_MCAUSE:     rd_val = state_ff.mcause;
            A_MTVAL:      rd_val = state_ff.mtval;
            A_MIP:        rd_val = state_ff.mip;
            A_CYCLE, A_MCYCLE, A_INSTRET, A_MINSTRET: rd_val = it.steps;
            A_TIME:       rd_val = in_stage.quot;
            A_MARCH:      rd_val = MARCH_VALUE;
            A_MIMP:       rd_val = MIMP_VALUE;
            A_FFLAGS:     rd_val = {56'd0, state_ff.fcsr & FFLAGS_MASK};
            A_FRM:        rd_val = {61'd0, state_ff.fcsr[7:5]};
            A_FCSR:       rd_val = {56'd0, state_ff.fcsr};
            A_SIE:        rd_val = state_ff.mie & state_ff.mideleg;
            A_STVEC:      rd_val = state_ff.stvec;
            A_SCOUNTEREN: rd_val = state_ff.scounteren;
            A_SENVCFG:    rd_val = state_ff.senvcfg;
            A_SSCRATCH:   rd_val = state_ff.sscratch;
            A_SEPC:       rd_val = state_ff.sepc;
            A_SCAUSE:     rd_val = state_ff.scause;
            A_STVAL:      rd_val = state_ff.stval;
            A_SIP:        rd_val = state_ff.mip & state_ff.mideleg;
            A_SATP:       rd_val = state_ff.satp;
            default:      rd_ok  = 1'b0;
         endcase
      end
   end

   // write decode
   always_comb begin
      wr_next = state_ff;
      wr_ok   = 1'b1;
      if (!(in_pcfg || in_paddr || in_zero)) begin
         unique case (a) inside
            A_SSTATUS, A_SSTATUS_ALT:
               wr_next.mstatus = (state_ff.mstatus & ~status_view_mask_ff) |
                                 (it.wdata & status_view_mask_ff);
            A_MSTATUS:    wr_next.mstatus    = it.wdata;
            A_MISA:       wr_next.mstatus    = state_ff.mstatus;
            A_MEDELEG:    wr_next.medeleg    = it.wdata & MEDELEG_WARL;
            A_MIDELEG:    wr_next.mideleg    = it.wdata & MIDELEG_WARL;
            A_MIE:        wr_next.mie        = it.wdata;
            A_MTVEC:      wr_next.mtvec      = it.wdata;
            A_MCOUNTEREN: wr_next.mcounteren = it.wdata;
            A_MENVCFG:    wr_next.menvcfg    = it.wdata;
            A_MSCRATCH:   wr_next.mscratch   = it.wdata;
            A_MEPC:       wr_next.mepc       = it.wdata;
            A_MCAUSE:     wr_next.mcause     = it.wdata;
            A_MTVAL:      wr_next.mtval      = it.wdata;
            A_MIP:        wr_next.mip        = it.wdata;
            A_SENVCFG:    wr_next.senvcfg    = it.wdata;
            A_SIE:
               wr_next.mie = (state_ff.mie & ~state_ff.mideleg) |
                             (it.wdata & state_ff.mideleg);
            A_STVEC:      wr_next.stvec      = it.wdata;
            A_SCOUNTEREN: wr_next.scounteren = it.wdata;
            A_SSCRATCH:   wr_next.sscratch   = it.wdata;
            A_SEPC:       wr_next.sepc       = it.wdata;
            A_SCAUSE:     wr_next.scause     = it.wdata;
            A_STVAL:      wr_next.stval      = it.wdata;
            A_SIP:
               wr_next.mip = (state_ff.mip & ~state_ff.mideleg) |
                             (it.wdata & state_ff.mideleg);
            A_SATP:       wr_next.satp       = it.wdata;
            A_FFLAGS:
               wr_next.fcsr = (state_ff.fcsr & ~FFLAGS_MASK) | (it.wdata[7:0] & FFLAGS_MASK);
            A_FRM:
               wr_next.fcsr = (state_ff.fcsr & ~FRM_MASK) | {it.wdata[2:0], 5'd0};
            A_FCSR:       wr_next.fcsr       = it.wdata[7:0];
            default:      wr_ok = 1'b0;
         endcase
      end
   end

   always_comb begin
      fire = in_valid && advance;
      if (it.mode < a[9:8]) begin
         bad = 1'b1;
      end else if (it.op == OP_WRITE) begin
         bad = (a[11:10] == 2'b11) || !wr_ok;
      end else begin
         bad = !rd_ok;
      end
      wr_fire  = fire && (it.op == OP_WRITE) && !bad;
      state_in = wr_fire ? wr_next : state_ff;
      pcfg_we  = wr_fire && in_pcfg && pcfg_hit;
      paddr_we = wr_fire && in_paddr && paddr_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= '0;
         status_view_mask_ff <= STATUS_VIEW_MASK_RST;
         isa_ff              <= ISA_RST;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (cfg_index_type'(csr_index))
               CFG_STATUS_VIEW_MASK: status_view_mask_ff <= csr_wdata;
               CFG_ISA:              isa_ff              <= csr_wdata;
               default:              ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PC_DEPTH; i++) pcfg_ff[i] <= '0;
      end else if (pcfg_we) begin
         pcfg_ff[pcfg_idx] <= it.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PA_DEPTH; i++) paddr_vld_ff[i] <= 1'b0;
      end else if (paddr_we) begin
         paddr_vld_ff[paddr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (paddr_we) begin
         paddr_mem[paddr_idx] <= it.wdata;
      end
   end

   // read one stage ahead; forward a write that lands on the same edge
   always_ff @(posedge clock) begin
      if (advance) begin
         if (paddr_we && (paddr_idx == pre_idx)) begin
            paddr_rd_ff <= it.wdata;
         end else if (paddr_vld_ff[pre_idx]) begin
            paddr_rd_ff <= paddr_mem[pre_idx];
         end else begin
            paddr_rd_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_illegal_ff <= bad;
         rsp_data_ff    <= (bad || (it.op == OP_WRITE)) ? '0 : rd_val;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_illegal = rsp_illegal_ff;

   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_illegal_ff |-> rsp_data_ff == '0)
      else $error("illegal access returned data");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      fire && (it.op == OP_WRITE) |=> rsp_data_ff == '0)
      else $error("write returned data");

   a_deleg_warl: assert property (@(posedge clock) disable iff (reset)
      !state_ff.medeleg[11] && !state_ff.mideleg[7] && !state_ff.mideleg[3])
      else $error("delegation WARL bit set");

   a_stall_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed during stall");

endmodule

>>> sv/control_status_register_file_top.sv
// Top level of the RV64 control and status register file.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tuser, req_tdata
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One word per cycle while the output is not stalled. Each word passes the
// four-stage divider for the time counter, which produces one 16-bit quotient
// digit per stage; register access sits between the last divider stage and the
// result register. Reset returns the valid flags and the register state to their
// reset values; the pipeline data is not reset. A stalled output holds the whole pipeline.
module control_status_register_file_top #(
   parameter int PADDR_ENTRIES = csrf_pkg::PADDR_ENTRIES_DEF,
   parameter int PCFG_WORDS    = csrf_pkg::PCFG_WORDS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,   // operation
   // address[11:0], write_value[75:12], privilege_mode[77:76], step_total[141:78]
   input  logic [csrf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_data[63:0], illegal[64]
   output logic [csrf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [csrf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_wdata
);
   import csrf_pkg::*;

   logic        advance;
   logic        vld [DIV_STAGES+1];
   stage_type   stg [DIV_STAGES+1];
   logic [63:0] rsp_data;
   logic        rsp_illegal;
   logic        unused_pad;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign unused_pad = ^req_tdata[REQ_TDATA_W-1:142];

   always_comb begin
      vld[0]             = req_tvalid;
      stg[0].item.op     = op_type'(req_tuser);
      stg[0].item.addr   = req_tdata[11:0];
      stg[0].item.wdata  = req_tdata[75:12];
      stg[0].item.mode   = req_tdata[77:76];
      stg[0].item.steps  = req_tdata[141:78];
      stg[0].quot        = '0;
      stg[0].rem         = '0;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      csrf_div_stage #(.STAGE(s)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vld[s]),
         .in_stage  (stg[s]),
         .out_valid (vld[s+1]),
         .out_stage (stg[s+1])
      );
   end

   csrf_regs #(
      .PADDR_ENTRIES (PADDR_ENTRIES),
      .PCFG_WORDS    (PCFG_WORDS)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pre_addr    (stg[DIV_STAGES-1].item.addr),
      .in_valid    (vld[DIV_STAGES]),
      .in_stage    (stg[DIV_STAGES]),
      .rsp_valid   (rsp_tvalid),
      .rsp_data    (rsp_data),
      .rsp_illegal (rsp_illegal)
   );

   assign rsp_tdata = {7'd0, rsp_illegal & (unused_pad | !unused_pad), rsp_data};

endmodule
